// ===== design/indexed_list_insert_remove_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Indexed list unit assertion macros
// Shared concurrent assertion forms; expect clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef INDEXED_LIST_INSERT_REMOVE_UNIT_DEFINES_SVH
`define INDEXED_LIST_INSERT_REMOVE_UNIT_DEFINES_SVH

// same-cycle implication
`define ILU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ILU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/ilu_pkg.sv =====
// ----------------------------------------------------------------------------
// Indexed list unit package
// Sizes, request/result types and controller/datapath interface types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ilu_pkg;

  localparam int DEPTH   = 64;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int POS_W   = 7;
  localparam int COUNT_W = 7;
  localparam int WORD_W  = 32;
  localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [1:0] {
    KIND_APPEND = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_READ   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    WR_NONE   = 2'd0,
    WR_APPEND = 2'd1,
    WR_PUT    = 2'd2,
    WR_SHIFT  = 2'd3
  } wr_sel_t;

  typedef struct packed {
    kind_t                     kind;
    logic [POS_W-1:0]          position;
    logic signed [WORD_W-1:0]  value;
  } in_req_t;

  typedef struct packed {
    logic signed [WORD_W-1:0]  read_value;
    logic [COUNT_W-1:0]        count;
    status_t                   status;
  } out_res_t;

  // controller -> datapath
  typedef struct packed {
    logic    load_req;
    logic    ptr_init;
    logic    ptr_step;
    logic    rd_en;
    wr_sel_t wr_sel;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    out_load;
    status_t out_status;
    logic    out_rd;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    kind_t kind;
    logic  bad_insert;
    logic  bad_access;
    logic  full;
    logic  ins_done;
    logic  rem_done;
    logic  out_free;
  } dp_sts_t;

endpackage

// ===== design/ilu_dp.sv =====
// ----------------------------------------------------------------------------
// Indexed list unit datapath
// Entry store, count, shift pointer, range checks and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "indexed_list_insert_remove_unit_defines.svh"

module ilu_dp
  import ilu_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  in_req_t  in_req,
  input  logic     out_stall,
  output logic     out_valid,
  output out_res_t out_res,
  input  dp_cmd_t  cmd,
  output dp_sts_t  sts
);

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rdata_r;
  in_req_t           req_r;
  logic [ADDR_W-1:0] ptr_r;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_res_t          out_res_r;

  logic [CMP_W-1:0]  pos_ext, cnt_ext, ptr_ext;
  logic [ADDR_W-1:0] pos_addr, ptr_dn, ptr_up, rd_addr, wr_addr;
  logic [WORD_W-1:0] wr_data;
  logic              wr_en, is_ins;

  assign pos_ext  = CMP_W'(req_r.position);
  assign cnt_ext  = CMP_W'(cnt_r);
  assign ptr_ext  = CMP_W'(ptr_r);
  assign pos_addr = ADDR_W'(pos_ext);
  assign ptr_dn   = ptr_r - ADDR_W'(1);
  assign ptr_up   = ptr_r + ADDR_W'(1);
  assign is_ins   = (req_r.kind == KIND_INSERT);

  always_comb begin
    sts.kind       = req_r.kind;
    sts.bad_insert = (pos_ext > cnt_ext);
    sts.bad_access = (pos_ext >= cnt_ext);
    sts.full       = (cnt_ext >= CMP_W'(DEPTH));
    sts.ins_done   = (ptr_ext == pos_ext);
    sts.rem_done   = ((ptr_ext + CMP_W'(1)) == cnt_ext);
    sts.out_free   = !out_valid_r || !out_stall;
  end

  // read port: direct read, or the neighbor feeding the current slot
  always_comb begin
    if (req_r.kind == KIND_READ) begin
      rd_addr = pos_addr;
    end else if (is_ins) begin
      rd_addr = ptr_dn;
    end else begin
      rd_addr = ptr_up;
    end
  end

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = ptr_r;
    wr_data = rdata_r;
    case (cmd.wr_sel)
      WR_APPEND: begin
        wr_addr = ADDR_W'(cnt_r);
        wr_data = req_r.value;
      end
      WR_PUT: begin
        wr_data = req_r.value;
      end
      WR_SHIFT: begin
        wr_data = rdata_r;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.cnt_inc) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (cmd.cnt_dec) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_r <= in_req;
    end
    if (cmd.ptr_init) begin
      ptr_r <= is_ins ? ADDR_W'(cnt_r) : pos_addr;
    end else if (cmd.ptr_step) begin
      ptr_r <= is_ins ? ptr_dn : ptr_up;
    end
    if (cmd.out_load) begin
      out_res_r.read_value <= cmd.out_rd ? signed'(rdata_r) : '0;
      out_res_r.count      <= COUNT_W'(cnt_ext);
      out_res_r.status     <= cmd.out_status;
    end
  end

  // entry store
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rdata_r <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  `ILU_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_ext <= CMP_W'(DEPTH), "count above depth")
  `ILU_ASSERT_NOW(a_cnt_onedir, 1'b1, !(cmd.cnt_inc && cmd.cnt_dec), "count up and down")
  `ILU_ASSERT_NOW(a_wr_span, wr_en, CMP_W'(wr_addr) <= cnt_ext, "write past list end")
  `ILU_ASSERT_NEXT(a_out_load, cmd.out_load, out_valid_r, "result load lost")

endmodule

// ===== design/ilu_ctrl.sv =====
// ----------------------------------------------------------------------------
// Indexed list unit controller
// Sequences decode, entry-by-entry shifting, reads and result hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ilu_ctrl
  import ilu_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_DECODE   = 6'b000010,
    S_SHIFT    = 6'b000100,
    S_SHIFT_WR = 6'b001000,
    S_READ     = 6'b010000,
    S_REPORT   = 6'b100000
  } state_t;

  state_t  state_r, state_nxt;
  status_t res_r, res_nxt;
  logic    use_rd_r, use_rd_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_nxt  = state_r;
    res_nxt    = res_r;
    use_rd_nxt = use_rd_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_nxt    = S_DECODE;
        end
      end
      S_DECODE: begin
        res_nxt    = ST_OK;
        use_rd_nxt = 1'b0;
        state_nxt  = S_REPORT;
        case (sts.kind)
          KIND_APPEND: begin
            if (sts.full) begin
              res_nxt = ST_FULL;
            end else begin
              cmd.wr_sel  = WR_APPEND;
              cmd.cnt_inc = 1'b1;
            end
          end
          KIND_INSERT: begin
            if (sts.bad_insert) begin
              res_nxt = ST_BAD_INDEX;
            end else if (sts.full) begin
              res_nxt = ST_FULL;
            end else begin
              cmd.ptr_init = 1'b1;
              state_nxt    = S_SHIFT;
            end
          end
          KIND_REMOVE: begin
            if (sts.bad_access) begin
              res_nxt = ST_BAD_INDEX;
            end else begin
              cmd.ptr_init = 1'b1;
              state_nxt    = S_SHIFT;
            end
          end
          default: begin
            if (sts.bad_access) begin
              res_nxt = ST_BAD_INDEX;
            end else begin
              state_nxt = S_READ;
            end
          end
        endcase
      end
      S_SHIFT: begin
        if (sts.kind == KIND_INSERT) begin
          if (sts.ins_done) begin
            cmd.wr_sel  = WR_PUT;
            cmd.cnt_inc = 1'b1;
            state_nxt   = S_REPORT;
          end else begin
            cmd.rd_en = 1'b1;
            state_nxt = S_SHIFT_WR;
          end
        end else begin
          if (sts.rem_done) begin
            cmd.cnt_dec = 1'b1;
            state_nxt   = S_REPORT;
          end else begin
            cmd.rd_en = 1'b1;
            state_nxt = S_SHIFT_WR;
          end
        end
      end
      S_SHIFT_WR: begin
        cmd.wr_sel   = WR_SHIFT;
        cmd.ptr_step = 1'b1;
        state_nxt    = S_SHIFT;
      end
      S_READ: begin
        cmd.rd_en  = 1'b1;
        use_rd_nxt = 1'b1;
        state_nxt  = S_REPORT;
      end
      S_REPORT: begin
        cmd.out_status = res_r;
        cmd.out_rd     = use_rd_r;
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r    <= res_nxt;
    use_rd_r <= use_rd_nxt;
  end

endmodule

// ===== design/indexed_list_insert_remove_unit.sv =====
// Path per request: append and refused requests go decode, report; read goes
//   decode, read, report; insert and remove shift between decode and report.
// Throughput: one request at a time, plus any wait for the result register;
//   the next is taken the cycle after the result is loaded.
//   Each moved entry takes an S_SHIFT read and an S_SHIFT_WR write in the store.
// Reset: count and result valid clear synchronously; entry contents stay undefined.
// ----------------------------------------------------------------------------
// Indexed list insert/remove unit
// Ordered list of signed words with append, insert, remove and read requests.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module indexed_list_insert_remove_unit
  import ilu_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  // request channel
  input  logic     in_valid,
  output logic     in_stall,
  input  in_req_t  in_req,
  // result channel
  output logic     out_valid,
  input  logic     out_stall,
  output out_res_t out_res
);

  // The controller steps through decode, shift and report; the datapath
  // owns the entry store, the count and the result register. The result
  // register decouples the sides: a new request is taken while a finished
  // result still waits downstream.
  dp_cmd_t cmd;
  dp_sts_t sts;

  ilu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Insert walks a pointer down from count, copying each entry one slot
  // up, then drops the value in at position. Remove walks up from position,
  // copying each entry one slot down, then shortens the list.
  ilu_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_res   (out_res),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// Indexed list unit testbench
// Drives append/insert/remove/read requests through the valid/stall channels,
// predicts each result from a shadow copy of the list and checks every field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb
  import ilu_pkg::*;
();

  // Shadow list plus queue of results still owed by the block.
  class list_scoreboard;
    logic signed [WORD_W-1:0] words [DEPTH];
    int unsigned held;
    out_res_t    awaited [$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned kind_seen [4];
    int unsigned full_seen;
    int unsigned bad_seen;

    function new();
      held = 0;
      mismatches = 0;
      checked = 0;
      full_seen = 0;
      bad_seen = 0;
      foreach (kind_seen[k]) kind_seen[k] = 0;
    endfunction

    // Apply one accepted request to the shadow list, queue its result.
    function void note_request(in_req_t req);
      out_res_t    res;
      int unsigned pos;
      int unsigned i;
      pos = req.position;
      res.read_value = '0;
      res.status = ST_OK;
      kind_seen[req.kind]++;
      case (req.kind)
        KIND_APPEND: begin
          if (held >= DEPTH) begin
            res.status = ST_FULL;
          end else begin
            words[held] = req.value;
            held++;
          end
        end
        KIND_INSERT: begin
          // range check wins over full check
          if (pos > held) begin
            res.status = ST_BAD_INDEX;
          end else if (held >= DEPTH) begin
            res.status = ST_FULL;
          end else begin
            for (i = held; i > pos; i--) words[i] = words[i-1];
            words[pos] = req.value;
            held++;
          end
        end
        KIND_REMOVE: begin
          if (pos >= held) begin
            res.status = ST_BAD_INDEX;
          end else begin
            for (i = pos; i + 1 < held; i++) words[i] = words[i+1];
            held--;
          end
        end
        default: begin
          if (pos >= held) begin
            res.status = ST_BAD_INDEX;
          end else begin
            res.read_value = words[pos];
          end
        end
      endcase
      res.count = COUNT_W'(held);
      if (res.status == ST_FULL) full_seen++;
      if (res.status == ST_BAD_INDEX) bad_seen++;
      awaited.push_back(res);
    endfunction

    // Compare one accepted result against the oldest queued one.
    function void check_result(out_res_t got);
      out_res_t want;
      if (awaited.size() == 0) begin
        $error("unexpected result: read_value %0d count %0d status %0d",
               got.read_value, got.count, got.status);
        mismatches++;
        return;
      end
      want = awaited.pop_front();
      checked++;
      if (got.read_value !== want.read_value) begin
        $error("read_value: expected %0d, got %0d", want.read_value, got.read_value);
        mismatches++;
      end
      if (got.count !== want.count) begin
        $error("count: expected %0d, got %0d", want.count, got.count);
        mismatches++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        mismatches++;
      end
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  in_req_t  in_req;
  logic     out_valid;
  logic     out_stall;
  out_res_t out_res;

  // Idle rates in percent, changed per phase by the main sequence.
  int unsigned send_idle;
  int unsigned recv_idle;
  // Main sequence raises this to ask the receiver for one long hold-off.
  bit          hold_go;
  // Random traffic alternates between filling and draining the list.
  bit          growing;

  list_scoreboard sb;

  indexed_list_insert_remove_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  always #6 clk = ~clk;

  function automatic in_req_t request_of(kind_t k, int unsigned pos,
                                         logic signed [WORD_W-1:0] val);
    in_req_t r;
    r.kind = k;
    r.position = POS_W'(pos);
    r.value = val;
    return r;
  endfunction

  // Random word, with the sign extremes and zero showing up often.
  function automatic logic signed [WORD_W-1:0] pick_word();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // Valid index for remove/read; 0 on an empty list (refused, still useful).
  function automatic int unsigned below_count();
    return (sb.held == 0) ? 0 : $urandom_range(sb.held - 1);
  endfunction

  // Mostly well-formed traffic that walks the list between empty and full,
  // with a slice of noise: any kind at any 7-bit position.
  function automatic in_req_t make_request();
    in_req_t     r;
    int unsigned pick;
    if (growing && sb.held == DEPTH && $urandom_range(3) == 0) growing = 1'b0;
    if (!growing && sb.held == 0 && $urandom_range(1) == 0) growing = 1'b1;
    pick = $urandom_range(99);
    r = request_of(kind_t'($urandom_range(3)), $urandom_range(127), pick_word());
    if (pick >= 15) begin
      if (growing) begin
        if (pick < 50) begin
          r.kind = KIND_APPEND;
        end else if (pick < 80) begin
          r.kind = KIND_INSERT;
          r.position = POS_W'($urandom_range(sb.held));
        end else begin
          r.kind = KIND_READ;
          r.position = POS_W'(below_count());
        end
      end else begin
        if (pick < 65) begin
          r.kind = KIND_REMOVE;
          r.position = POS_W'(below_count());
        end else if (pick < 85) begin
          r.kind = KIND_READ;
          r.position = POS_W'(below_count());
        end else begin
          r.kind = KIND_INSERT;
          r.position = POS_W'($urandom_range(sb.held));
        end
      end
    end
    return r;
  endfunction

  // Offer one request, hold it until taken, then maybe leave a gap.
  task automatic send(input in_req_t req);
    int unsigned gap;
    in_valid <= 1'b1;
    in_req <= req;
    do @(posedge clk); while (in_stall);
    sb.note_request(req);
    if ($urandom_range(99) < send_idle) begin
      gap = $urandom_range(4, 1);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Result side: check on every accepted result, stall at random, and
  // serve the long hold-off when the main sequence asks for it.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) sb.check_result(out_res);
      if (hold_go) begin
        hold_left = 300;
        hold_go = 1'b0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle);
      end
    end
  end

  // Main sequence: reset, directed corner cases, then three random phases.
  initial begin
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req = '0;
    out_stall = 1'b0;
    hold_go = 1'b0;
    growing = 1'b1;
    send_idle = 27;
    recv_idle = 49;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty list: every indexed access is out of range.
    send(request_of(KIND_READ, 0, 0));
    send(request_of(KIND_REMOVE, 0, 0));
    send(request_of(KIND_INSERT, 1, 32'h1234_5678));
    // Insert at position == count, then appends with word extremes.
    send(request_of(KIND_INSERT, 0, 32'h7fff_ffff));
    send(request_of(KIND_APPEND, 99, 32'h8000_0000));
    send(request_of(KIND_APPEND, 0, 32'h0000_0000));
    send(request_of(KIND_APPEND, 0, 32'hffff_ffff));
    // Inserts in the middle, at the front and at the end.
    send(request_of(KIND_INSERT, 1, 32'h5555_5555));
    send(request_of(KIND_INSERT, 0, 32'haaaa_aaaa));
    send(request_of(KIND_INSERT, 6, 32'h0000_0001));
    // Insert past the end, all position bits set.
    send(request_of(KIND_INSERT, 127, 32'hdead_beef));
    // Reads: first, last, at count, far beyond.
    send(request_of(KIND_READ, 0, 32'hffff_ffff));
    send(request_of(KIND_READ, 6, 0));
    send(request_of(KIND_READ, 7, 0));
    send(request_of(KIND_READ, 64, 0));
    // Removes: middle, front, last, then at count.
    send(request_of(KIND_REMOVE, 2, 0));
    send(request_of(KIND_REMOVE, 0, 0));
    send(request_of(KIND_REMOVE, 4, 0));
    send(request_of(KIND_REMOVE, 4, 0));
    send(request_of(KIND_READ, 1, 0));
    send(request_of(KIND_READ, 3, 0));

    // Phase 0: sender idles less than receiver; phase 1 swapped;
    // phase 2 no idling, opened by a long receiver hold-off so the
    // block backs up and stalls its request side.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle = 27;
          recv_idle = 49;
        end
        1: begin
          send_idle = 49;
          recv_idle = 27;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
          hold_go = 1'b1;
        end
      endcase
      repeat (267) send(make_request());
    end
    in_valid <= 1'b0;

    // Drain, then allow the longest shift time for anything stray.
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);

    $display("Covered %0d requests: %0d appends, %0d inserts, %0d removes, %0d reads",
             sb.checked, sb.kind_seen[KIND_APPEND], sb.kind_seen[KIND_INSERT],
             sb.kind_seen[KIND_REMOVE], sb.kind_seen[KIND_READ]);
    $display("%0d refused on a full list, %0d refused as out of range",
             sb.full_seen, sb.bad_seen);
    if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
